// ===== hdl/jlh_pkg.sv =====
// ----------------------------------------------------------------------------
// jlh_pkg
// Shared types and constants for the streaming lookup2 hash block.
// ----------------------------------------------------------------------------
package jlh_pkg;

  localparam logic [31:0] GOLDEN   = 32'h9e3779b9;
  localparam int          MIX_ROWS = 9;
  localparam int          RND_W    = 4;

  // byte positions inside a 12-byte block
  localparam logic [3:0] POS_B    = 4'd4;
  localparam logic [3:0] POS_C    = 4'd8;
  localparam logic [3:0] POS_LAST = 4'd11;

  // job handed from the front end to the mix engine
  typedef struct packed {
    logic        load;   // reload a/b/c before anything else
    logic [31:0] init;
    logic        mix;    // full block: add words, then mix into state
    logic        fin;    // key end: final mix on a copy, emit c
    logic [31:0] wa;
    logic [31:0] wb;
    logic [31:0] wc;
    logic [31:0] cnt;    // byte count at key end
  } jlh_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MIX,
    BK_FADD,
    BK_FIN
  } jlh_state_t;

  typedef enum logic [1:0] {
    TGT_A,
    TGT_B,
    TGT_C
  } jlh_tgt_t;

  typedef struct packed {
    jlh_tgt_t   tgt;
    logic [4:0] shamt;
  } jlh_row_t;

  // one row of the mix: target word and shift amount (b rows shift left)
  function automatic jlh_row_t jlh_row(input logic [RND_W-1:0] rnd);
    jlh_row_t r;
    unique case (rnd)
      4'd0:    r = '{TGT_A, 5'd13};
      4'd1:    r = '{TGT_B, 5'd8};
      4'd2:    r = '{TGT_C, 5'd13};
      4'd3:    r = '{TGT_A, 5'd12};
      4'd4:    r = '{TGT_B, 5'd16};
      4'd5:    r = '{TGT_C, 5'd5};
      4'd6:    r = '{TGT_A, 5'd3};
      4'd7:    r = '{TGT_B, 5'd10};
      4'd8:    r = '{TGT_C, 5'd15};
      default: r = '{TGT_A, 5'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/jlh_in_if.sv =====
// ----------------------------------------------------------------------------
// jlh_in_if
// Key byte channel: valid/ready plus one key byte and its framing flags.
// ----------------------------------------------------------------------------
interface jlh_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        key_start;
  logic        key_end;
  logic [31:0] init_value;

  modport source (output valid, data_byte, byte_valid, key_start, key_end, init_value,
                  input ready);
  modport sink   (input valid, data_byte, byte_valid, key_start, key_end, init_value,
                  output ready);
endinterface

// ===== hdl/jlh_out_if.sv =====
// ----------------------------------------------------------------------------
// jlh_out_if
// Hash result channel: valid/ready plus the 32-bit hash.
// ----------------------------------------------------------------------------
interface jlh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// ===== hdl/jlh_front.sv =====
// ----------------------------------------------------------------------------
// jlh_front
// Byte collector: packs key bytes little-endian into block words and emits
// a job at key start, at each full block and at key end.
// ----------------------------------------------------------------------------
module jlh_front (
  input  logic               clk,
  input  logic               rst_n,
  jlh_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               q_push,
  output jlh_pkg::jlh_job_t  q_job
);

  logic [3:0]  pos_r,  pos_nxt;
  logic [31:0] wa_r,   wa_nxt;
  logic [31:0] wb_r,   wb_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [31:0] cnt_r,  cnt_nxt;

  logic        accept;
  logic        start;
  logic        take;
  logic [3:0]  base_pos;
  logic [31:0] base_wa, base_wb, base_cnt;
  logic [23:0] base_pend;
  logic [31:0] byte_sh;
  logic        blk_done;
  logic [31:0] new_wa, new_wb;
  logic [23:0] new_pend;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = in_ch.key_start;
  assign take        = in_ch.byte_valid;

  always_comb begin
    base_pos  = start ? 4'd0  : pos_r;
    base_wa   = start ? 32'd0 : wa_r;
    base_wb   = start ? 32'd0 : wb_r;
    base_pend = start ? 24'd0 : pend_r;
    base_cnt  = start ? 32'd0 : cnt_r;

    byte_sh  = {24'd0, in_ch.data_byte} << {base_pos[1:0], 3'b000};
    blk_done = take && (base_pos == jlh_pkg::POS_LAST);

    new_wa   = base_wa;
    new_wb   = base_wb;
    new_pend = base_pend;
    if (take) begin
      if (base_pos < jlh_pkg::POS_B) begin
        new_wa = base_wa | byte_sh;
      end else if (base_pos < jlh_pkg::POS_C) begin
        new_wb = base_wb | byte_sh;
      end else if (!blk_done) begin
        new_pend = base_pend | byte_sh[23:0];
      end
    end

    cnt_nxt = base_cnt + {31'd0, take};
    if (blk_done) begin
      pos_nxt  = 4'd0;
      wa_nxt   = 32'd0;
      wb_nxt   = 32'd0;
      pend_nxt = 24'd0;
    end else begin
      pos_nxt  = take ? base_pos + 4'd1 : base_pos;
      wa_nxt   = new_wa;
      wb_nxt   = new_wb;
      pend_nxt = new_pend;
    end
  end

  // tail c bytes sit one byte up: the low byte of c carries the length
  always_comb begin
    q_push     = accept && (start || blk_done || in_ch.key_end);
    q_job.load = start;
    q_job.init = in_ch.init_value;
    q_job.mix  = blk_done;
    q_job.fin  = in_ch.key_end;
    q_job.wa   = new_wa;
    q_job.wb   = new_wb;
    q_job.wc   = blk_done ? {in_ch.data_byte, base_pend} : {new_pend, 8'd0};
    q_job.cnt  = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 4'd0;
      wa_r   <= 32'd0;
      wb_r   <= 32'd0;
      pend_r <= 24'd0;
      cnt_r  <= 32'd0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      wa_r   <= wa_nxt;
      wb_r   <= wb_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/jlh_fifo.sv =====
// ----------------------------------------------------------------------------
// jlh_fifo
// Short job queue between the byte collector and the mix engine.
// ----------------------------------------------------------------------------
module jlh_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jlh_pkg::jlh_job_t  push_job,
  output logic               full,
  input  logic               pop,
  output jlh_pkg::jlh_job_t  pop_job,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jlh_pkg::jlh_job_t mem [DEPTH];

  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/jlh_back.sv =====
// ----------------------------------------------------------------------------
// jlh_back
// Mix engine: holds a/b/c, runs the lookup2 mix one row per cycle (the last
// final row waits on a stalled output) and drives the registered hash output.
// ----------------------------------------------------------------------------
module jlh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  jlh_pkg::jlh_job_t  q_job,
  output logic               q_pop,
  jlh_out_if.source          out_ch
);

  localparam int RW = jlh_pkg::RND_W;

  jlh_pkg::jlh_state_t state_r, state_nxt;

  logic [31:0]   sa_r, sa_nxt, sb_r, sb_nxt, sc_r, sc_nxt;
  logic [31:0]   x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic          fin_r, fin_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic [31:0]   hash_r, hash_nxt;

  jlh_pkg::jlh_row_t row;
  logic [31:0]   rx, ry, rz;
  logic          last;
  logic          can_out;
  logic [31:0]   ba, bb, bc;

  assign last    = (rnd_r == RW'(jlh_pkg::MIX_ROWS - 1));
  assign can_out = !ov_r || out_ch.ready;
  assign out_ch.valid      = ov_r;
  assign out_ch.hash_value = hash_r;

  // one row of the mix
  always_comb begin
    row = jlh_pkg::jlh_row(rnd_r);
    rx  = x_r;
    ry  = y_r;
    rz  = z_r;
    unique case (row.tgt)
      jlh_pkg::TGT_A: rx = (x_r - y_r - z_r) ^ (z_r >> row.shamt);
      jlh_pkg::TGT_B: ry = (y_r - z_r - x_r) ^ (x_r << row.shamt);
      jlh_pkg::TGT_C: rz = (z_r - x_r - y_r) ^ (y_r >> row.shamt);
      default:        rx = x_r;
    endcase
  end

  always_comb begin
    ba = q_job.load ? jlh_pkg::GOLDEN : sa_r;
    bb = q_job.load ? jlh_pkg::GOLDEN : sb_r;
    bc = q_job.load ? q_job.init      : sc_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jlh_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_job.mix) begin
            state_nxt = jlh_pkg::BK_MIX;
          end else if (q_job.fin) begin
            state_nxt = jlh_pkg::BK_FIN;
          end
        end
      end
      jlh_pkg::BK_MIX: begin
        if (last) begin
          state_nxt = fin_r ? jlh_pkg::BK_FADD : jlh_pkg::BK_IDLE;
        end
      end
      jlh_pkg::BK_FADD: state_nxt = jlh_pkg::BK_FIN;
      jlh_pkg::BK_FIN: begin
        if (last && can_out) begin
          state_nxt = jlh_pkg::BK_IDLE;
        end
      end
      default: state_nxt = jlh_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop    = 1'b0;
    sa_nxt   = sa_r;
    sb_nxt   = sb_r;
    sc_nxt   = sc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    rnd_nxt  = rnd_r;
    fin_nxt  = fin_r;
    cnt_nxt  = cnt_r;
    hash_nxt = hash_r;
    ov_nxt   = ov_r && !out_ch.ready;
    unique case (state_r)
      jlh_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          sa_nxt  = ba;
          sb_nxt  = bb;
          sc_nxt  = bc;
          x_nxt   = ba + q_job.wa;
          y_nxt   = bb + q_job.wb;
          z_nxt   = q_job.mix ? bc + q_job.wc : bc + q_job.wc + q_job.cnt;
          rnd_nxt = '0;
          fin_nxt = q_job.fin;
          cnt_nxt = q_job.cnt;
        end
      end
      jlh_pkg::BK_MIX: begin
        x_nxt   = rx;
        y_nxt   = ry;
        z_nxt   = rz;
        rnd_nxt = last ? '0 : rnd_r + RW'(1);
        if (last) begin
          sa_nxt = rx;
          sb_nxt = ry;
          sc_nxt = rz;
        end
      end
      jlh_pkg::BK_FADD: begin
        z_nxt   = z_r + cnt_r;
        rnd_nxt = '0;
      end
      jlh_pkg::BK_FIN: begin
        if (!last) begin
          x_nxt   = rx;
          y_nxt   = ry;
          z_nxt   = rz;
          rnd_nxt = rnd_r + RW'(1);
        end else if (can_out) begin
          hash_nxt = rz;
          ov_nxt   = 1'b1;
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jlh_pkg::BK_IDLE;
      sa_r    <= 32'd0;
      sb_r    <= 32'd0;
      sc_r    <= 32'd0;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
      sc_r    <= sc_nxt;
      rnd_r   <= rnd_nxt;
      fin_r   <= fin_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cnt_r  <= cnt_nxt;
    hash_r <= hash_nxt;
  end

  a_fadd_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == jlh_pkg::BK_FADD |-> (x_r == sa_r) && (y_r == sb_r))
    else $error("final copy of a/b differs from held state");

  a_mix_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jlh_pkg::BK_MIX) && last && !fin_r |=> state_r == jlh_pkg::BK_IDLE)
    else $error("block mix did not return to idle");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == jlh_pkg::BK_FIN && last))
    else $error("result raised outside final mix");

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != jlh_pkg::BK_IDLE |-> rnd_r <= RW'(jlh_pkg::MIX_ROWS - 1))
    else $error("mix row counter overran");

endmodule

// ===== hdl/jenkins_lookup2_hash_top.sv =====
// ----------------------------------------------------------------------------
// jenkins_lookup2_hash_top
// Streaming 32-bit lookup2 hash: byte collector, job queue, mix engine.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                           | transfer
//  in_ch    | in  | data_byte, byte_valid, key_start, key_end, init   | one key item
//  out_ch   | out | hash_value                                        | one hash per key end
//
//  Items are taken one per cycle while the job queue has room.
//  A full 12-byte block costs an add and 9 mix rows in the mix engine,
//  so long keys stream at one byte per cycle; each key end costs a final
//  add and 9 more rows in the same engine, also when it completes a
//  block; a key start without key end costs only its load step.
//  Reset is synchronous and clears a/b/c, the collector's byte count, the row counter and the queue; no sweep.
//  A stalled output holds the engine only at its last final-mix row; input
//  stalls only when the queue is full.
// ----------------------------------------------------------------------------
module jenkins_lookup2_hash_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  jlh_in_if.sink      in_ch,
  jlh_out_if.source   out_ch
);

  jlh_pkg::jlh_job_t push_job, pop_job;
  logic              q_push, q_full, q_pop, q_empty;

  jlh_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  jlh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  jlh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
